@@ rtl/pbps_pkg.sv @@
// ----------------------------------------------------------------------------
// pbps_pkg - shared types and constants of the Bezier path sampler
// Sequencer states, path index phases, step limits and the control structs
// passed between the top level and the segment sequencer.
// ----------------------------------------------------------------------------
package pbps_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int STEP_W          = 16;

  localparam logic [STEP_W-1:0] T_STEP_RESET = 16'd4096;
  localparam logic [STEP_W-1:0] MIN_STEP     = 16'd1024;

  // where the incoming point sits in its path
  typedef enum logic [1:0] {
    PH_NONE,   // no point seen yet
    PH_ONE,    // next index is 1
    PH_EVEN,   // next index is even, >= 2
    PH_ODD     // next index is odd, >= 3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ADD,
    S_ROT,
    S_FIN,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic              go;
    logic              cubic;
    logic              last_path;
    logic [STEP_W-1:0] step;
  } seg_cmd_t;

  typedef struct packed {
    logic busy;
    logic emit_valid;
    logic segment_end;
    logic path_end;
  } seq_stat_t;

endpackage

@@ rtl/pbps_if.sv @@
// ----------------------------------------------------------------------------
// pbps_if - channel interfaces of the Bezier path sampler
// Control point input, sample output and step register write channel.
// ----------------------------------------------------------------------------
interface pbps_point_if #(
  parameter int COORD_WIDTH = pbps_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          final_point;

  modport source (output valid, pos_x, pos_y, pos_z, final_point, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

interface pbps_sample_if #(
  parameter int COORD_WIDTH = pbps_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          segment_end;
  logic                          path_end;

  modport source (output valid, out_x, out_y, out_z, segment_end, path_end, input ready);
  modport sink   (input valid, out_x, out_y, out_z, segment_end, path_end, output ready);
endinterface

interface pbps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pbps_pkg::STEP_W-1:0]   t_step;

  modport source (output valid, t_step, input ready);
  modport sink   (input valid, t_step, output ready);
endinterface

@@ rtl/pbps_lerp.sv @@
// ----------------------------------------------------------------------------
// pbps_lerp - shared linear interpolation unit
// y = a + floor(((b - a) * t + 2^15) / 2^16), product registered, result
// valid the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module pbps_lerp #(
  parameter int PW = pbps_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                           clk,
  input  logic signed [PW-1:0]           a,
  input  logic signed [PW-1:0]           b,
  input  logic [pbps_pkg::STEP_W-1:0]    t,
  output logic signed [PW-1:0]           y
);
  import pbps_pkg::*;

  localparam int DW  = PW + 1;
  localparam int PRW = DW + STEP_W + 1;
  localparam logic signed [PRW-1:0] RND_HALF = PRW'(2 ** (STEP_W - 1));

  logic signed [DW-1:0]         diff;
  logic signed [PRW-1:0]        prod;
  logic signed [PRW-1:0]        prod_r;
  logic signed [PW-1:0]         a_r;
  logic signed [PRW-1:0]        rnd;
  logic signed [PRW-STEP_W-1:0] q;
  logic signed [PW+1:0]         sum;

  assign diff = {b[PW-1], b} - {a[PW-1], a};
  assign prod = PRW'(diff) * PRW'($signed({1'b0, t}));

  always_ff @(posedge clk) begin
    prod_r <= prod;
    a_r    <= a;
  end

  assign rnd = prod_r + RND_HALF;
  assign q   = rnd[PRW-1:STEP_W];
  assign sum = q + {{2{a_r[PW-1]}}, a_r};
  assign y   = sum[PW-1:0];

endmodule

@@ rtl/pbps_seq.sv @@
// ----------------------------------------------------------------------------
// pbps_seq - segment sequencer
// Walks t over one segment and runs de Casteljau per coordinate on the shared
// lerp unit. Work values sit in a 4-entry ring: lerp reads the two head
// entries and appends at the tail, rotations realign the ring between levels.
// ----------------------------------------------------------------------------
module pbps_seq #(
  parameter int CW = pbps_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pbps_pkg::seg_cmd_t            cmd,
  input  logic [3:0][2:0][CW:0]         pts,
  input  logic                          emit_take,
  output pbps_pkg::seq_stat_t           stat,
  output logic [2:0][CW-1:0]            res
);
  import pbps_pkg::*;

  localparam int PW = CW + 1;
  localparam logic [2:0] RING_LEN   = 3'd4;
  localparam logic [1:0] LAST_COORD = 2'd2;
  localparam logic [1:0] LV_CUBIC   = 2'd3;
  localparam logic [1:0] LV_QUAD    = 2'd2;
  localparam logic [1:0] LV_LAST    = 2'd1;
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  seq_state_t state, state_next;

  logic                    cubic;
  logic                    last_path;
  logic [STEP_W-1:0]       step;
  logic [3:0][2:0][PW-1:0] pr;
  logic [3:0][PW-1:0]      w;
  logic [1:0]              lv;
  logic [2:0]              cnt;
  logic [1:0]              coord;
  logic [STEP_W-1:0]       t;

  logic signed [PW-1:0]    lerp_y;
  logic [STEP_W:0]         t_sum;
  logic                    last_smp;
  logic [2:0]              cnt_inc;
  logic                    level_full;
  logic                    rot_done;

  logic                    do_start;
  logic                    do_load;
  logic                    do_shift;
  logic                    do_rot;
  logic                    do_fin;
  logic                    do_emit;

  logic signed [PW:0]      fin_s;
  logic signed [PW-1:0]    fin_r;
  logic [CW-1:0]           fin_sat;

  pbps_lerp #(.PW(PW)) u_lerp (
    .clk (clk),
    .a   (w[0]),
    .b   (w[1]),
    .t   (t),
    .y   (lerp_y)
  );

  assign t_sum      = {1'b0, t} + {1'b0, step};
  assign last_smp   = t_sum[STEP_W];
  assign cnt_inc    = cnt + 3'd1;
  assign level_full = (cnt_inc == {1'b0, lv});
  assign rot_done   = (cnt_inc == RING_LEN);

  // round half up to Q.8, then clamp
  assign fin_s = {w[3][PW-1], w[3]} + (PW+1)'(1);
  assign fin_r = fin_s[PW:1];
  always_comb begin
    if (fin_r[PW-1] != fin_r[PW-2]) begin
      fin_sat = fin_r[PW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      fin_sat = fin_r[CW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.go) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_MUL;
      S_MUL:  state_next = S_ADD;
      S_ADD: begin
        if (!level_full) begin
          state_next = S_MUL;
        end else if (lv == LV_LAST) begin
          state_next = S_FIN;
        end else begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        if (rot_done) state_next = S_MUL;
      end
      S_FIN: begin
        state_next = (coord == LAST_COORD) ? S_EMIT : S_LOAD;
      end
      S_EMIT: begin
        if (emit_take) state_next = last_smp ? S_IDLE : S_LOAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    do_start = 1'b0;
    do_load  = 1'b0;
    do_shift = 1'b0;
    do_rot   = 1'b0;
    do_fin   = 1'b0;
    do_emit  = 1'b0;
    case (state)
      S_IDLE:  do_start = cmd.go;
      S_LOAD:  do_load  = 1'b1;
      S_MUL:   ;
      S_ADD:   do_shift = 1'b1;
      S_ROT:   do_rot   = 1'b1;
      S_FIN:   do_fin   = 1'b1;
      S_EMIT:  do_emit  = 1'b1;
      default: ;
    endcase
  end

  assign stat.busy        = (state != S_IDLE);
  assign stat.emit_valid  = do_emit;
  assign stat.segment_end = last_smp;
  assign stat.path_end    = last_smp & last_path;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      pr        <= pts;
      cubic     <= cmd.cubic;
      last_path <= cmd.last_path;
      step      <= (cmd.step < MIN_STEP) ? MIN_STEP : cmd.step;
      t         <= '0;
      coord     <= '0;
    end
    if (do_load) begin
      for (int k = 0; k < 4; k++) begin
        w[k]     <= pr[k][0];
        pr[k][0] <= pr[k][1];
        pr[k][1] <= pr[k][2];
        pr[k][2] <= pr[k][0];
      end
      lv  <= cubic ? LV_CUBIC : LV_QUAD;
      cnt <= '0;
    end
    if (do_shift) begin
      w   <= {lerp_y, w[3], w[2], w[1]};
      cnt <= cnt_inc;
    end
    if (do_rot) begin
      w <= {w[0], w[3], w[2], w[1]};
      if (rot_done) begin
        cnt <= '0;
        lv  <= lv - 2'd1;
      end else begin
        cnt <= cnt_inc;
      end
    end
    if (do_fin) begin
      res   <= {fin_sat, res[2], res[1]};
      coord <= coord + 2'd1;
    end
    if (do_emit && emit_take) begin
      coord <= '0;
      t     <= t_sum[STEP_W-1:0];
    end
  end

endmodule

@@ rtl/piecewise_bezier_path_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_bezier_path_sampler_unit - piecewise Bezier path sampler
// Control points come in one word at a time, final_point marking the end of
// a path. Each odd point from index 3 on closes a cubic segment (quadratic
// when it is the last point, which is then dropped), and a last point at an
// even index closes a quadratic one; every segment runs from the midpoint of
// a control pair and is sampled at t = 0, t_step, ... while t < 1 (t_step is
// unsigned Q0.16, values under 1024 act as 1024, so at most 64 samples).
// Flow: a point that closes no segment is taken whenever the sequencer is
// idle. A point that closes a segment holds ready low while its samples are
// produced; all math goes through one shared registered lerp unit, one
// coordinate at a time, and each sample waits while the output register is
// full and not taken.
// The last sample sits in an output register, so the next point can be
// taken while it waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module piecewise_bezier_path_sampler_unit #(
  parameter int COORD_WIDTH = pbps_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pbps_point_if.sink    points,
  pbps_sample_if.source samples,
  pbps_cfg_if.sink      cfg
);
  import pbps_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 1;   // doubled (Q.9) coordinates

  // config
  logic [STEP_W-1:0] t_step;

  // path state: last three points, oldest at index 0
  phase_t                  phase, phase_next;
  logic [2:0][2:0][CW-1:0] win;
  logic [2:0][CW-1:0]      cur;

  logic accept;
  logic emit_odd;
  logic emit_even;

  seg_cmd_t                cmd;
  seq_stat_t               stat;
  logic [3:0][2:0][PW-1:0] pts;
  logic [2:0][CW-1:0]      res;

  // output register
  logic                    out_valid;
  logic                    out_load;

  function automatic logic [PW-1:0] sx(input logic [CW-1:0] v);
    sx = {v[CW-1], v};
  endfunction

  function automatic logic [PW-1:0] dbl(input logic [CW-1:0] v);
    dbl = {v, 1'b0};
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_step <= T_STEP_RESET;
    end else if (cfg.valid) begin
      t_step <= cfg.t_step;
    end
  end

  // ----------------------------------------------------------------- input
  assign cur[0] = points.pos_x;
  assign cur[1] = points.pos_y;
  assign cur[2] = points.pos_z;

  // ready drops as soon as a segment starts, for its whole length
  assign points.ready = !stat.busy;
  assign accept       = points.valid & points.ready;

  // odd index >= 3 closes a segment; even index closes one only if last
  assign emit_odd  = (phase == PH_ODD);
  assign emit_even = (phase == PH_EVEN) & points.final_point;

  assign cmd.go        = accept & (emit_odd | emit_even);
  assign cmd.cubic     = emit_odd & !points.final_point;
  assign cmd.last_path = points.final_point;
  assign cmd.step      = t_step;

  // segment control points in Q.9: midpoints are plain sums, corners doubled
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (emit_odd) begin
        pts[0][c] = sx(win[0][c]) + sx(win[1][c]);
        pts[1][c] = dbl(win[1][c]);
        pts[2][c] = dbl(win[2][c]);
        pts[3][c] = sx(win[2][c]) + sx(cur[c]);
      end else begin
        pts[0][c] = sx(win[1][c]) + sx(win[2][c]);
        pts[1][c] = dbl(win[2][c]);
        pts[2][c] = dbl(cur[c]);
        pts[3][c] = '0;   // unused by a quadratic
      end
    end
  end

  // index phase
  always_comb begin
    phase_next = phase;
    if (points.final_point) begin
      phase_next = PH_NONE;
    end else begin
      case (phase)
        PH_NONE: phase_next = PH_ONE;
        PH_ONE:  phase_next = PH_EVEN;
        PH_EVEN: phase_next = PH_ODD;
        PH_ODD:  phase_next = PH_EVEN;
        default: phase_next = PH_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NONE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // window only feeds segments once refilled, so no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= cur;
    end
  end

  // ------------------------------------------------------------- sequencer
  pbps_seq #(.CW(CW)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pts       (pts),
    .emit_take (out_load),
    .stat      (stat),
    .res       (res)
  );

  // ---------------------------------------------------------------- output
  assign out_load = stat.emit_valid & (!out_valid | samples.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      samples.out_x       <= res[0];
      samples.out_y       <= res[1];
      samples.out_z       <= res[2];
      samples.segment_end <= stat.segment_end;
      samples.path_end    <= stat.path_end;
    end
  end

  assign samples.valid = out_valid;

  // ------------------------------------------------------------ assertions
  a_path_end_closes_seg: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.path_end |-> samples.segment_end)
    else $error("path_end without segment_end");

  a_last_point_resets_phase: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready && points.final_point |=> phase == PH_NONE)
    else $error("phase not cleared after last point");

  a_no_take_while_sampling: assert property (@(posedge clk) disable iff (rst)
    stat.emit_valid |-> !points.ready)
    else $error("input ready while a segment is being sampled");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.emit_valid))
    else $error("output word appeared without a sample");

endmodule
